/* rtl/dkm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dkm_pkg
// Shared types and constants for the debounced key to MIDI note event block.
// ----------------------------------------------------------------------------
package dkm_pkg;

	// sample kind carried on tuser
	typedef enum logic {
		OP_KEY    = 1'b0,
		OP_BUTTON = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic {
		REG_DEBOUNCE_TICKS = 1'b0,
		REG_NOTE_VELOCITY  = 1'b1
	} cfg_reg_t;

	localparam logic [7:0] TICKS_RESET    = 8'd50;
	localparam logic [6:0] VELOCITY_RESET = 7'd100;
	localparam logic [3:0] OCTAVE_RESET   = 4'd3;
	localparam logic [3:0] OCTAVE_MAX     = 4'd10;
	localparam logic [3:0] OCTAVE_MIN     = 4'd1;
	localparam logic [7:0] SEMITONES      = 8'd12;
	localparam logic [7:0] NOTE_MAX       = 8'd127;
	localparam int         NUM_BUTTONS    = 2;

	// one key entry: debounce counter and the note last sent
	typedef struct packed {
		logic [7:0] cnt;
		logic [6:0] note;
	} key_entry_t;

	// one button sample handed to the octave unit
	typedef struct packed {
		logic       en;
		logic       pressed;
		logic       sel;      // 0 = octave up, 1 = octave down
		logic [7:0] ticks;
	} btn_step_t;

endpackage
`default_nettype wire

/* rtl/dkm_key_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dkm_key_mem
// Per-key state memory: one write port, one registered read port, a valid bit
// per entry so unwritten entries read as an idle counter, and a bypass for a
// read issued at the same edge as a write to the same entry.
// ----------------------------------------------------------------------------
module dkm_key_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      rd_en,
	input  wire  [AW-1:0]            rd_addr,
	output dkm_pkg::key_entry_t      rd_data,
	input  wire                      wr_en,
	input  wire  [AW-1:0]            wr_addr,
	input  dkm_pkg::key_entry_t      wr_data
);

	dkm_pkg::key_entry_t mem [DEPTH];
	dkm_pkg::key_entry_t mem_rd_q;
	dkm_pkg::key_entry_t byp_data_q;
	logic [DEPTH-1:0]    valid_q;
	logic                rd_vld_q;
	logic                byp_q;

	// storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// storage read, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			byp_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
				byp_q    <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// bypass data for a same-entry write at the read edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			byp_data_q <= wr_data;
		end
	end

	// read result: bypass, then stored entry, else idle counter
	always_comb begin
		if (byp_q) begin
			rd_data = byp_data_q;
		end else if (rd_vld_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data.cnt  = 8'd0;
			rd_data.note = mem_rd_q.note;
		end
	end

endmodule
`default_nettype wire

/* rtl/dkm_octave.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dkm_octave
// Octave buttons: a debounce counter per button and the octave register.
// ----------------------------------------------------------------------------
module dkm_octave (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dkm_pkg::btn_step_t  step,
	output logic [3:0]          octave
);

	logic [7:0] cnt_q [dkm_pkg::NUM_BUTTONS];
	logic [3:0] octave_q;
	logic [7:0] cnt_sel;

	assign cnt_sel = cnt_q[step.sel];
	assign octave  = octave_q;

	// counter and octave update for one button sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dkm_pkg::NUM_BUTTONS; i++) begin
				cnt_q[i] <= 8'd0;
			end
			octave_q <= dkm_pkg::OCTAVE_RESET;
		end else if (step.en) begin
			if (step.pressed) begin
				cnt_q[step.sel] <= step.ticks;
				if (cnt_sel == 8'd0) begin
					if (!step.sel && octave_q < dkm_pkg::OCTAVE_MAX) begin
						octave_q <= octave_q + 4'd1;
					end else if (step.sel && octave_q > dkm_pkg::OCTAVE_MIN) begin
						octave_q <= octave_q - 4'd1;
					end
				end
			end else if (cnt_sel != 8'd0) begin
				cnt_q[step.sel] <= cnt_sel - 8'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_octave_range: assert property (@(posedge clk) disable iff (!arst_n)
		octave_q >= dkm_pkg::OCTAVE_MIN && octave_q <= dkm_pkg::OCTAVE_MAX)
		else $error("octave out of range");
`endif

endmodule
`default_nettype wire

/* rtl/debounced_key_to_midi_note_events.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_key_to_midi_note_events
// Debounces active-low key and octave button samples and emits MIDI
// note-on / note-off items.
// ----------------------------------------------------------------------------
// A sample is registered in stage 1, and its result in the output register on m_tdata.
// Throughput: one sample per cycle; the key memory read-modify-write over two
// stages is kept at that rate by a same-entry bypass in the memory. A sample
// waits in stage 1 while an event sits unaccepted on the output.
// Reset: counters read as zero through per-key valid bits (no clearing pass),
// octave 3, debounce_ticks 50, note_velocity 100.
// ----------------------------------------------------------------------------
module debounced_key_to_midi_note_events #(
	parameter int NUM_KEYS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// sample stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [4:0] index, [5] level, [12:6] key_note
	input  wire  [0:0]  s_tuser,   // [0] op
	// event stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [6:0] note, [13:7] velocity
	output logic [0:0]  m_tuser,   // [0] note_on
	// configuration writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [7:0]  cfg_data
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	// configuration registers
	logic [7:0] ticks_q;
	logic [6:0] velocity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q    <= dkm_pkg::TICKS_RESET;
			velocity_q <= dkm_pkg::VELOCITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dkm_pkg::cfg_reg_t'(cfg_index))
				dkm_pkg::REG_DEBOUNCE_TICKS: ticks_q    <= cfg_data;
				dkm_pkg::REG_NOTE_VELOCITY:  velocity_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input field split
	logic [4:0]        in_index;
	logic              in_level;
	logic [6:0]        in_key_note;
	logic [KW+4:0]     in_index_wide;
	logic [KW-1:0]     in_addr;
	logic              accept;

	assign in_index      = s_tdata[4:0];
	assign in_level      = s_tdata[5];
	assign in_key_note   = s_tdata[12:6];
	assign in_index_wide = (KW+5)'(in_index);
	assign in_addr       = in_index_wide[KW-1:0];
	assign accept        = s_tvalid && s_tready;

	// stage 1 registers
	logic              v_s1;
	dkm_pkg::op_t      op_s1;
	logic              in_range_s1;
	logic              btn_ok_s1;
	logic              sel_s1;
	logic              pressed_s1;
	logic [6:0]        key_note_s1;
	logic [KW-1:0]     addr_s1;
	logic              adv;

	assign adv      = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= dkm_pkg::op_t'(s_tuser[0]);
			in_range_s1 <= 32'(in_index) < NUM_KEYS;
			btn_ok_s1   <= in_index[4:1] == 4'd0;
			sel_s1      <= in_index[0];
			pressed_s1  <= !in_level;
			key_note_s1 <= in_key_note;
			addr_s1     <= in_addr;
		end
	end

	// key state memory
	dkm_pkg::key_entry_t rd_entry;
	dkm_pkg::key_entry_t wr_entry;
	logic                wr_en;

	dkm_key_mem #(
		.DEPTH (NUM_KEYS),
		.AW    (KW)
	) u_key_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_entry)
	);

	// octave buttons
	dkm_pkg::btn_step_t btn_step;
	logic [3:0]         octave;

	assign btn_step.en      = adv && op_s1 == dkm_pkg::OP_BUTTON && btn_ok_s1;
	assign btn_step.pressed = pressed_s1;
	assign btn_step.sel     = sel_s1;
	assign btn_step.ticks   = ticks_q;

	dkm_octave u_octave (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (btn_step),
		.octave (octave)
	);

	// note number: base + 12 * octave, clamped
	logic [7:0] note_sum;
	logic [6:0] note_on_val;

	assign note_sum    = 8'(key_note_s1) + 8'(8'(octave) * dkm_pkg::SEMITONES);
	assign note_on_val = (note_sum > dkm_pkg::NOTE_MAX) ? 7'(dkm_pkg::NOTE_MAX)
		: note_sum[6:0];

	// key read-modify-write and event selection
	logic       key_act;
	logic [7:0] cnt_dec;
	logic       emit;
	logic       emit_on;
	logic [6:0] emit_note;

	assign key_act = op_s1 == dkm_pkg::OP_KEY && in_range_s1;
	assign cnt_dec = rd_entry.cnt - 8'd1;

	always_comb begin
		wr_en     = 1'b0;
		wr_entry  = rd_entry;
		emit      = 1'b0;
		emit_on   = 1'b0;
		emit_note = rd_entry.note;
		if (adv && key_act) begin
			if (rd_entry.cnt == 8'd0) begin
				if (pressed_s1) begin
					wr_en         = 1'b1;
					wr_entry.cnt  = ticks_q;
					wr_entry.note = note_on_val;
					emit          = 1'b1;
					emit_on       = 1'b1;
					emit_note     = note_on_val;
				end
			end else if (pressed_s1) begin
				wr_en        = 1'b1;
				wr_entry.cnt = ticks_q;
			end else begin
				wr_en        = 1'b1;
				wr_entry.cnt = cnt_dec;
				emit         = cnt_dec == 8'd0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tuser <= emit_on;
			m_tdata <= {2'b00, (emit_on ? velocity_q : 7'd0), emit_note};
		end
	end

`ifndef SYNTHESIS
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |-> m_tvalid && !m_tready)
		else $error("stage 1 stalled with output free");
	a_off_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[13:7] == 7'd0)
		else $error("note-off with nonzero velocity");
	a_write_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> v_s1 && key_act)
		else $error("key memory written without a key item");
	a_event_from_key: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("event lost before output register");
`endif

endmodule
`default_nettype wire
